### sv/cobs_pkg.sv
// ----------------------------------------------------------------------------
// cobs_pkg: shared types for the COBS frame decoder
// Frame state, status codes and per-byte result bundle used by the top level
// and the byte step logic.
// ----------------------------------------------------------------------------
package cobs_pkg;

  // Width of the capacity register, the byte counter and the length field
  localparam int CNT_W = 13;

  // Capacity after reset
  localparam logic [CNT_W-1:0] CAP_RESET = 13'd4096;

  // Code byte that opens a full block with no trailing zero
  localparam logic [7:0] CODE_FULL = 8'hFF;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  // Frame status reported on the last byte
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_CODE = 2'd1,
    ST_OVERRUN   = 2'd2,
    ST_CAPACITY  = 2'd3
  } cobs_status_t;

  // Decoder state carried between bytes of a frame
  typedef struct packed {
    logic [7:0]       bytes_left;
    logic             expect_code;
    logic             first_block;
    logic             previous_code_full;
    logic [CNT_W-1:0] produced_count;
    cobs_status_t     committed_status;
    logic             pending_capacity_error;
  } cobs_state_t;

  // State at reset and after every frame end
  localparam cobs_state_t STATE_CLEAR = '{
    bytes_left:             8'd0,
    expect_code:            1'b1,
    first_block:            1'b1,
    previous_code_full:     1'b0,
    produced_count:         '0,
    committed_status:       ST_OK,
    pending_capacity_error: 1'b0
  };

  // Result of one decoded byte
  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             frame_done;
    cobs_status_t     status;
    logic [CNT_W-1:0] decoded_length;
  } cobs_result_t;

endpackage

### sv/cobs_step.sv
// ----------------------------------------------------------------------------
// cobs_step: next-state and result logic for one encoded byte
// Purely combinational; the caller holds the state and result registers.
// ----------------------------------------------------------------------------
module cobs_step
  import cobs_pkg::*;
(
  input  cobs_state_t       state,
  input  logic [7:0]        in_byte,
  input  logic              frame_end,
  input  logic [CNT_W-1:0]  limit,
  output cobs_state_t       state_next,
  output cobs_result_t      result
);

  always_comb begin
    cobs_state_t  s;
    cobs_result_t r;
    logic         cap_hit;

    s       = state;
    r       = '0;
    r.status = ST_OK;
    cap_hit = (state.produced_count >= limit);

    if (state.committed_status == ST_OK) begin
      if (state.expect_code) begin
        // restored zero of the previous block, unless it was a full block
        if (!state.first_block && !state.previous_code_full) begin
          if (cap_hit) begin
            s.committed_status = ST_CAPACITY;
          end else begin
            s.produced_count = state.produced_count + 1'b1;
            r.out_byte       = BYTE_ZERO;
            r.byte_valid     = 1'b1;
          end
        end
        // new code byte
        if (s.committed_status == ST_OK) begin
          if (in_byte == BYTE_ZERO) begin
            s.committed_status = ST_ZERO_CODE;
          end else begin
            s.first_block        = 1'b0;
            s.previous_code_full = (in_byte == CODE_FULL);
            s.bytes_left         = in_byte - 8'd1;
            s.expect_code        = (in_byte == 8'd1);
          end
        end
      end else begin
        // data byte inside a block; capacity error waits for block end
        if (!state.pending_capacity_error) begin
          if (cap_hit) begin
            s.pending_capacity_error = 1'b1;
          end else begin
            s.produced_count = state.produced_count + 1'b1;
            r.out_byte       = in_byte;
            r.byte_valid     = 1'b1;
          end
        end
        s.bytes_left = state.bytes_left - 8'd1;
        if (s.bytes_left == 8'd0) begin
          s.expect_code = 1'b1;
          if (s.pending_capacity_error) begin
            s.committed_status = ST_CAPACITY;
          end
        end
      end
    end

    // frame end: report status and length, then start over
    if (frame_end) begin
      r.frame_done = 1'b1;
      if (s.committed_status != ST_OK) begin
        r.status = s.committed_status;
      end else if (!s.expect_code) begin
        r.status = ST_OVERRUN;
      end else begin
        r.status         = ST_OK;
        r.decoded_length = s.produced_count;
      end
      s = STATE_CLEAR;
    end

    state_next = s;
    result     = r;
  end

endmodule

### sv/cobs_frame_decoder.sv
// ----------------------------------------------------------------------------
// cobs_frame_decoder: streaming COBS frame decoder, one byte per transaction
// Decodes encoded bytes, restores zeros, checks capacity and reports the
// frame status and decoded length on the last byte of each frame.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata[7:0] in_byte, tlast frame_end
//  m_*      out  m_tvalid/m_tready  tdata out_byte/decoded_length, tuser
//                                   byte_valid/status, tlast frame_done
//  cfg_*    in   cfg_wr_en          cfg_wr_data out_capacity
//
//  One byte per cycle sustained while m_tready is high: an input register
//  feeds the byte step logic and the result register; the frame state updates
//  in that same cycle. Each result passes the input and the result register.
//  rst is synchronous: frame state clears and the capacity returns to 4096.
//  A stall on m_tready holds the result and the waiting input byte.
// ----------------------------------------------------------------------------
module cobs_frame_decoder
  import cobs_pkg::*;
#(
  parameter int unsigned MAX_OUT_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,   // out_capacity
  // encoded byte stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,       // [7:0] in_byte
  input  logic              s_tlast,       // frame_end
  // decoded byte stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata,       // [7:0] out_byte, [20:8] decoded_length
  output logic [2:0]        m_tuser,       // [0] byte_valid, [2:1] status
  output logic              m_tlast        // frame_done
);

  localparam int LIM_W = 17;

  logic [CNT_W-1:0] out_capacity;
  logic [CNT_W-1:0] limit;

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             in_last;

  cobs_state_t      state;
  cobs_state_t      state_next;
  cobs_result_t     step_result;
  cobs_result_t     res;
  logic             res_valid;
  logic             advance;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CAP_RESET;
    end else if (cfg_wr_en) begin
      out_capacity <= cfg_wr_data;
    end
  end

  // limit in force is the smaller of the register and MAX_OUT_BYTES
  assign limit = ({{(LIM_W-CNT_W){1'b0}}, out_capacity} > LIM_W'(MAX_OUT_BYTES))
               ? CNT_W'(MAX_OUT_BYTES) : out_capacity;

  // pipeline control
  assign advance  = in_valid && (!res_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  cobs_step u_step (
    .state      (state),
    .in_byte    (in_byte),
    .frame_end  (in_last),
    .limit      (limit),
    .state_next (state_next),
    .result     (step_result)
  );

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_CLEAR;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step_result;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {3'b000, res.decoded_length, res.out_byte};
  assign m_tuser  = {res.status, res.byte_valid};
  assign m_tlast  = res.frame_done;

  // a result without a decoded byte carries a zero byte
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0)
    else $error("out_byte nonzero without byte_valid");

  // status is reported only on the frame's last byte
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser[2:1] == ST_OK)
    else $error("status set before frame end");

  // length only with a good frame end
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (!m_tlast || m_tuser[2:1] != ST_OK) |-> m_tdata[20:8] == '0)
    else $error("decoded_length set without good frame end");

  // after a frame end the state is back at its start values
  assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> state == STATE_CLEAR)
    else $error("frame state not cleared at frame end");

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the COBS frame decoder
// Drives encoded frames on the input stream, predicts every decoded result in
// a cycle-free model of the decoder and compares each output transaction field
// by field. Directed frames hit the error and capacity corners, then random
// well-formed, cut, corrupted and noise frames run under several idle mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import cobs_pkg::*;

  localparam int unsigned MAX_OUT     = 4096;
  localparam int unsigned QUIET_LIMIT = 3000;   // cycles with no transaction
  localparam int unsigned HOLD_CYCLES = 300;    // long output hold-off
  localparam int unsigned FULL_LEN    = 200;    // payload that fills the limit

  typedef enum int unsigned {
    FRAME_GOOD,
    FRAME_CUT,
    FRAME_CORRUPT,
    FRAME_NOISE
  } frame_kind_t;

  // DUT ports; every input is known from time zero
  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              cfg_wr_en   = 1'b0;
  logic [CNT_W-1:0]  cfg_wr_data = '0;
  logic              s_tvalid    = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata     = 8'h00;   // [7:0] in_byte
  logic              s_tlast     = 1'b0;    // frame_end
  logic              m_tvalid;
  logic              m_tready    = 1'b0;
  logic [23:0]       m_tdata;               // [7:0] out_byte, [20:8] decoded_length
  logic [2:0]        m_tuser;               // [0] byte_valid, [2:1] status
  logic              m_tlast;               // frame_done

  // Predictor state: configuration and per-frame decode state
  logic [CNT_W-1:0]  cap_reg = CAP_RESET;
  logic [7:0]        blk_left;
  logic              want_code;
  logic              at_first_block;
  logic              last_code_full;
  logic [CNT_W-1:0]  out_count;
  cobs_status_t      frame_status;
  logic              cap_pending;

  cobs_result_t      expected_q[$];
  logic [7:0]        enc_q[$];              // encoded frame being sent

  int unsigned       src_idle_pct   = 0;
  int unsigned       sink_stall_pct = 0;
  int unsigned       hold_request   = 0;
  int unsigned       hold_left      = 0;
  int unsigned       quiet_cycles   = 0;
  int unsigned       mismatches     = 0;

  cobs_frame_decoder #(
    .MAX_OUT_BYTES (MAX_OUT)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  // Frame state at reset and after each frame end
  function automatic void frame_restart();
    blk_left       = 8'd0;
    want_code      = 1'b1;
    at_first_block = 1'b1;
    last_code_full = 1'b0;
    out_count      = '0;
    frame_status   = ST_OK;
    cap_pending    = 1'b0;
  endfunction

  // One encoded byte in, one decoded result out
  function automatic cobs_result_t decode_step(logic [7:0] b, logic last);
    cobs_result_t     r;
    logic [CNT_W-1:0] lim;
    r   = '0;
    lim = (cap_reg > MAX_OUT) ? CNT_W'(MAX_OUT) : cap_reg;
    if (frame_status == ST_OK) begin
      if (want_code) begin
        // restored zero of the block just finished, checked first
        if (!at_first_block && !last_code_full) begin
          if (out_count >= lim) begin
            frame_status = ST_CAPACITY;
          end else begin
            out_count    = out_count + 1'b1;
            r.out_byte   = BYTE_ZERO;
            r.byte_valid = 1'b1;
          end
        end
        if (frame_status == ST_OK) begin
          if (b == BYTE_ZERO) begin
            frame_status = ST_ZERO_CODE;
          end else begin
            at_first_block = 1'b0;
            last_code_full = (b == CODE_FULL);
            blk_left       = b - 8'd1;
            want_code      = (blk_left == 8'd0);
          end
        end
      end else begin
        if (!cap_pending) begin
          if (out_count >= lim) begin
            cap_pending = 1'b1;
          end else begin
            out_count    = out_count + 1'b1;
            r.out_byte   = b;
            r.byte_valid = 1'b1;
          end
        end
        blk_left = blk_left - 8'd1;
        if (blk_left == 8'd0) begin
          want_code = 1'b1;
          if (cap_pending) frame_status = ST_CAPACITY;
        end
      end
    end

    if (last) begin
      r.frame_done = 1'b1;
      if (frame_status != ST_OK) begin
        r.status = frame_status;
      end else if (!want_code) begin
        r.status = ST_OVERRUN;
      end else begin
        r.status         = ST_OK;
        r.decoded_length = out_count;
      end
      frame_restart();
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: ready pattern and result checking
  // ---------------------------------------------------------------------------

  // Ready driver, with a counted hold-off on request
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each output transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    cobs_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: tdata %h tuser %h tlast %b",
               m_tdata, m_tuser, m_tlast);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        check_field("out_byte",       want.out_byte,       m_tdata[7:0]);
        check_field("byte_valid",     want.byte_valid,     m_tuser[0]);
        check_field("frame_done",     want.frame_done,     m_tlast);
        check_field("status",         want.status,         m_tuser[2:1]);
        check_field("decoded_length", want.decoded_length, m_tdata[20:8]);
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side helpers, all entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // Offer one byte, predict its result, hold until the transaction
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    expected_q.push_back(decode_step(b, last));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_frame();
    foreach (enc_q[i]) send_byte(enc_q[i], i == enc_q.size() - 1);
  endtask

  // Drop valid and let every pending result drain
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CNT_W-1:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cap_reg = value;
  endtask

  // COBS-encode a random payload of len bytes into enc_q
  task automatic encode_random(input int unsigned len, input int unsigned zero_pct);
    int unsigned code_idx;
    int unsigned code;
    logic [7:0]  b;
    enc_q.delete();
    enc_q.push_back(BYTE_ZERO);
    code_idx = 0;
    code     = 1;
    repeat (len) begin
      b = ($urandom_range(0, 99) < zero_pct) ? BYTE_ZERO : 8'($urandom_range(1, 255));
      if (b == BYTE_ZERO) begin
        enc_q[code_idx] = 8'(code);
        code_idx = enc_q.size();
        enc_q.push_back(BYTE_ZERO);
        code = 1;
      end else begin
        enc_q.push_back(b);
        code++;
        if (code == CODE_FULL) begin
          enc_q[code_idx] = CODE_FULL;
          code_idx = enc_q.size();
          enc_q.push_back(BYTE_ZERO);
          code = 1;
        end
      end
    end
    enc_q[code_idx] = 8'(code);
  endtask

  // One random frame: mostly well formed, some cut, corrupted or pure noise
  task automatic build_frame();
    frame_kind_t kind;
    int unsigned roll;
    int unsigned len;
    int unsigned keep;
    int unsigned idx;
    roll = $urandom_range(0, 9);
    kind = (roll < 7) ? FRAME_GOOD : (roll == 7) ? FRAME_CUT :
           (roll == 8) ? FRAME_CORRUPT : FRAME_NOISE;
    // long payloads are rare so runs of full blocks appear without slowing the run
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 600) : $urandom_range(0, 24);
    case ($urandom_range(0, 2))
      0: encode_random(len, 0);
      1: encode_random(len, 10);
      default: encode_random(len, 50);
    endcase
    case (kind)
      FRAME_CUT: begin
        keep = $urandom_range(1, enc_q.size());
        while (enc_q.size() > keep) void'(enc_q.pop_back());
      end
      FRAME_CORRUPT: begin
        idx = $urandom_range(0, enc_q.size() - 1);
        enc_q[idx] = $urandom_range(0, 1) ? BYTE_ZERO : 8'($urandom_range(0, 255));
      end
      FRAME_NOISE: begin
        enc_q.delete();
        repeat ($urandom_range(1, 16)) enc_q.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Ok frames, restored zeros, zero codes and overrun at reset capacity
  task automatic test_basic_frames();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    enc_q = '{8'h01};                   send_frame();  // empty payload
    enc_q = '{8'h03, 8'h7F, 8'h80};     send_frame();  // data bit extremes
    enc_q = '{8'h02, 8'hFF, 8'h01};     send_frame();  // restored zero
    enc_q = '{8'h00};                   send_frame();  // zero code first
    enc_q = '{8'h02, 8'hAA, 8'h00, 8'h55}; send_frame(); // zero code later, rest ignored
    enc_q = '{8'h04, 8'h01, 8'h02};     send_frame();  // block open at frame end
    enc_q = '{8'h01, 8'h01};            send_frame();  // single restored zero
    wait_idle();
  endtask

  // Capacity at zero and one: pending error, overrun instead, zero checked first
  task automatic test_capacity_edges();
    set_capacity('0);
    enc_q = '{8'h01};                   send_frame();
    enc_q = '{8'h02, 8'h55};            send_frame();  // block completes: capacity
    enc_q = '{8'h03, 8'h55};            send_frame();  // block open: overrun
    set_capacity(CNT_W'(1));
    enc_q = '{8'h02, 8'h55, 8'h00};     send_frame();  // restored zero over limit
    enc_q = '{8'h02, 8'h55};            send_frame();
    wait_idle();
  endtask

  // Long frames with no zeros: exactly at the limit, then one byte over it
  task automatic test_max_frames();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    set_capacity(CNT_W'(FULL_LEN));
    encode_random(FULL_LEN, 0);
    send_frame();
    encode_random(FULL_LEN + 1, 0);
    send_frame();
    wait_idle();
  endtask

  // Output held off for a long stretch while input is still offered
  task automatic test_output_hold();
    int unsigned sent;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    set_capacity(CAP_RESET);
    sent = 0;
    hold_request = HOLD_CYCLES;
    while (sent < 60) begin
      build_frame();
      sent += enc_q.size();
      send_frame();
    end
    wait_idle();
  endtask

  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned sink_pct,
                                     input logic [CNT_W-1:0] cap, input int unsigned n_items);
    int unsigned sent;
    set_capacity(cap);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    sent = 0;
    while (sent < n_items) begin
      build_frame();
      sent += enc_q.size();
      send_frame();
    end
    wait_idle();
  endtask

  initial begin
    frame_restart();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_basic_frames();
    test_capacity_edges();
    test_max_frames();
    test_output_hold();
    test_random_traffic(0,  0,  CAP_RESET,                      200);
    test_random_traffic(47, 0,  CNT_W'($urandom_range(0, 60)),  300);
    test_random_traffic(0,  47, {CNT_W{1'b1}},                  300);
    test_random_traffic(10, 10, CNT_W'(1),                      150);
    test_random_traffic(0,  0,  CNT_W'($urandom_range(0, 20)),  200);

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
